// ===== hw/rtl/crrq_pkg.sv =====
// Shared types, codes and AES-128 helpers for the CTR decrypt report queue.
// No dependencies; imported by the queue top level.
package crrq_pkg;

   // Item opcodes
   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_QUEUED = 3'd0;
   localparam logic [2:0] ST_REPLAY = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_NOKEY  = 3'd3;
   localparam logic [2:0] ST_GIVEN  = 3'd4;
   localparam logic [2:0] ST_EMPTY  = 3'd5;
   localparam logic [2:0] ST_RSTDON = 3'd6;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_KEY_HIGH  = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW   = 2'd1;
   localparam logic [1:0] CSR_NONCE     = 2'd2;
   localparam logic [1:0] CSR_KEY_READY = 2'd3;

   localparam int AES_ROUNDS = 10;

   typedef logic [7:0] byte_type;

   localparam byte_type SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   // Multiply by x in GF(2^8)
   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Expand the round key by one step; byte 0 sits in the top bits
   function automatic logic [127:0] key_step(input logic [127:0] rk, input byte_type rcon);
      byte_type   k [16];
      logic [127:0] res;
      for (int i = 0; i < 16; i++) k[i] = rk[127 - 8*i -: 8];
      k[0] = k[0] ^ SBOX[k[13]] ^ rcon;
      k[1] = k[1] ^ SBOX[k[14]];
      k[2] = k[2] ^ SBOX[k[15]];
      k[3] = k[3] ^ SBOX[k[12]];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = k[i];
      return res;
   endfunction

   // One cipher round without the key addition: SubBytes, ShiftRows, and MixColumns unless last
   function automatic logic [127:0] aes_round(input logic [127:0] blk, input logic last);
      byte_type   t [16];
      byte_type   s [16];
      byte_type   a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) t[i] = SBOX[blk[127 - 8*i -: 8]];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            s[i + 4*c] = t[i + 4*((c + i) % 4)];
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0  = s[4*c];
            a1  = s[4*c+1];
            a2  = s[4*c+2];
            a3  = s[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

endpackage

// ===== hw/rtl/ctr_decrypt_replay_report_queue.sv =====
// Replay-guarded AES-128-CTR report decrypter with a report queue.
// Depends on crrq_pkg and crrq_ram.
//
// Every request gives exactly one response. A packet runs one AES round per
// cycle over ten rounds, then, unless the queue is full, makes two writes
// through the single queue write port, then goes to the response register;
// a pop reads the RAM, whose read data is registered, and replay, reset,
// empty and key-not-ready requests go straight to the result step. The next
// request is taken in the same cycle that a finished response moves into
// the response register, so a response waiting under rsp_stall does not
// block the next request from being worked on up to its own result.
module ctr_decrypt_replay_report_queue
   import crrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   // requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_packet_counter,
   input  logic [63:0] req_cipher_high,
   input  logic [63:0] req_cipher_low,
   // responses
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_report,
   output logic [5:0]  rsp_occupancy
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(QUEUE_DEPTH - 2);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_AES, S_WR0, S_WR1, S_POP, S_FIN
   } state_type;

   // configuration registers
   logic [63:0] key_high_ff, key_low_ff, nonce_ff;
   logic        key_ready_ff;

   // control and data state
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [31:0]      next_ctr_ff, next_ctr_in;
   logic [127:0]     blk_ff, blk_in;
   logic [127:0]     rk_ff, rk_in;
   logic [7:0]       rcon_ff, rcon_in;
   logic [3:0]       round_ff, round_in;
   logic [127:0]     cipher_ff, cipher_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic [63:0]      res_report_ff, res_report_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [63:0]      rsp_report_ff, rsp_report_in;
   logic [5:0]       rsp_occ_ff, rsp_occ_in;

   // memory port
   logic             ram_we, ram_re;
   logic [PTR_W-1:0] ram_waddr;
   logic [63:0]      ram_wdata, ram_rdata;

   logic             out_free, can_take, take;
   logic [127:0]     rk_next;
   logic [CNT_W+5:0] occ_wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign can_take  = (state_ff == S_IDLE) || (state_ff == S_FIN && out_free);
   assign take      = req_valid && can_take;
   assign req_stall = !can_take;
   assign rk_next   = key_step(rk_ff, rcon_ff);
   assign occ_wide  = {{6{1'b0}}, held_ff};

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // Next-state logic: accept, AES rounds, queue writes, pop read, response
   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_in       = held_ff;
      next_ctr_in   = next_ctr_ff;
      blk_in        = blk_ff;
      rk_in         = rk_ff;
      rcon_in       = rcon_ff;
      round_in      = round_ff;
      cipher_in     = cipher_ff;
      res_status_in = res_status_ff;
      res_report_in = res_report_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_report_in = rsp_report_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = cipher_ff[127:64] ^ blk_ff[127:64];

      case (state_ff)
         S_AES: begin
            // one round per cycle
            blk_in   = aes_round(blk_ff, round_ff == 4'(AES_ROUNDS)) ^ rk_next;
            rk_in    = rk_next;
            rcon_in  = xtime(rcon_ff);
            round_in = round_ff + 1'b1;
            if (round_ff == 4'(AES_ROUNDS)) begin
               if (held_ff <= CNT_LIMIT) begin
                  state_in = S_WR0;
               end else begin
                  res_status_in = ST_FULL;
                  state_in      = S_FIN;
               end
            end
         end
         S_WR0: begin
            // write the high half of the decrypted report
            ram_we    = 1'b1;
            wr_ptr_in = ptr_inc(wr_ptr_ff);
            state_in  = S_WR1;
         end
         S_WR1: begin
            // write the low half of the decrypted report
            ram_we        = 1'b1;
            ram_wdata     = cipher_ff[63:0] ^ blk_ff[63:0];
            wr_ptr_in     = ptr_inc(wr_ptr_ff);
            held_in       = held_ff + 2'd2;
            res_status_in = ST_QUEUED;
            state_in      = S_FIN;
         end
         S_POP: begin
            res_report_in = ram_rdata;
            res_status_in = ST_GIVEN;
            rd_ptr_in     = ptr_inc(rd_ptr_ff);
            held_in       = held_ff - 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            // hand the result to the response register
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_report_in = res_report_ff;
               rsp_occ_in    = occ_wide[5:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
         end
      endcase

      // take a new request; results that need no work go straight to S_FIN
      if (take) begin
         res_report_in = '0;
         state_in      = S_FIN;
         if (req_opcode == OP_RESET) begin
            next_ctr_in   = '0;
            res_status_in = ST_RSTDON;
         end else if (req_opcode != OP_PACKET && req_opcode != OP_POP) begin
            res_status_in = ST_EMPTY;
         end else if (!key_ready_ff) begin
            res_status_in = ST_NOKEY;
         end else if (req_opcode == OP_PACKET) begin
            if (req_packet_counter < next_ctr_ff) begin
               res_status_in = ST_REPLAY;
            end else begin
               next_ctr_in = req_packet_counter + 1'b1;
               blk_in      = {nonce_ff, req_packet_counter, 32'h0}
                             ^ {key_high_ff, key_low_ff};
               rk_in       = {key_high_ff, key_low_ff};
               rcon_in     = 8'h01;
               round_in    = 4'd1;
               cipher_in   = {req_cipher_high, req_cipher_low};
               state_in    = S_AES;
            end
         end else begin
            if (held_ff == '0) begin
               res_status_in = ST_EMPTY;
            end else begin
               ram_re   = 1'b1;
               state_in = S_POP;
            end
         end
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         nonce_ff     <= '0;
         key_ready_ff <= 1'b0;
         state_ff     <= S_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         next_ctr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_HIGH:  key_high_ff  <= csr_data;
               CSR_KEY_LOW:   key_low_ff   <= csr_data;
               CSR_NONCE:     nonce_ff     <= csr_data;
               CSR_KEY_READY: key_ready_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         next_ctr_ff  <= next_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff        <= blk_in;
      rk_ff         <= rk_in;
      rcon_ff       <= rcon_in;
      round_ff      <= round_in;
      cipher_ff     <= cipher_in;
      res_status_ff <= res_status_in;
      res_report_ff <= res_report_in;
      rsp_status_ff <= rsp_status_in;
      rsp_report_ff <= rsp_report_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   crrq_ram #(
      .WIDTH (64),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_report    = rsp_report_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef SYNTHESIS
   // queue never holds more than its depth
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_MAX)
      else $error("held count above queue depth");

   // writes to the store only in the two write steps
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_WR0 || state_ff == S_WR1))
      else $error("queue write outside write phase");

   // a pop read is followed by the data capture step
   a_pop_follow: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (state_ff == S_POP))
      else $error("pop read not followed by capture");

   // no request taken while the cipher is running
   a_aes_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AES) |-> req_stall)
      else $error("request taken during AES rounds");

   // report is zero unless a report is given
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_GIVEN) |-> (rsp_report == '0))
      else $error("nonzero report without report given");
`endif

endmodule

// ===== hw/rtl/crrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/ctr_decrypt_replay_report_queue_tb.sv =====
// Testbench for ctr_decrypt_replay_report_queue: random and directed requests
// checked against an in-bench AES-128-CTR report queue predictor. Depends on crrq_pkg.
`timescale 1ns / 100ps
module ctr_decrypt_replay_report_queue_tb
   import crrq_pkg::*;
();

   localparam int DEPTH = 32;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] counter;
      logic [63:0] chigh;
      logic [63:0] clow;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] report;
      logic [5:0]  occupancy;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_packet_counter = '0;
   logic [63:0] req_cipher_high = '0;
   logic [63:0] req_cipher_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_report;
   logic [5:0]  rsp_occupancy;

   ctr_decrypt_replay_report_queue #(.QUEUE_DEPTH(DEPTH)) dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [63:0] m_key_high, m_key_low, m_nonce;
   logic        m_key_ready;
   logic [63:0] m_store [DEPTH];
   int unsigned m_rd, m_wr, m_held;
   logic [31:0] m_next_ctr;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int          errors = 0;
   bit          calm = 1'b0;
   bit          req_fire = 1'b0;
   int          req_gap = 0;
   int          rsp_gap = 0;

   function automatic logic [7:0] gmul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // encrypt one block with the current key; byte 0 in the top bits
   function automatic logic [127:0] keystream(input logic [127:0] din);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] rk [16];
      logic [7:0] a0, a1, a2, a3, al, k0, k1, k2, k3, rc;
      logic [127:0] key, res;
      key = {m_key_high, m_key_low};
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         b[i] = din[127-8*i -: 8] ^ rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) t[i] = SBOX[b[i]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) b[i+4*c] = t[i + 4*((c+i)%4)];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               b[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
               b[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
               b[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
               b[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
            end
         end
         k0 = SBOX[rk[13]] ^ rc; k1 = SBOX[rk[14]]; k2 = SBOX[rk[15]]; k3 = SBOX[rk[12]];
         rk[0] ^= k0; rk[1] ^= k1; rk[2] ^= k2; rk[3] ^= k3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rc = gmul2(rc);
         for (int i = 0; i < 16; i++) b[i] ^= rk[i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = b[i];
      return res;
   endfunction

   // advance the predictor by one request and return its response
   function automatic response_type predict_report(input request_type rq);
      response_type rs;
      logic [127:0] ks;
      rs = '0;
      if (rq.opcode == OP_RESET) begin
         m_next_ctr = '0;
         rs.status = ST_RSTDON;
      end else if (rq.opcode != OP_PACKET && rq.opcode != OP_POP) begin
         rs.status = ST_EMPTY;
      end else if (!m_key_ready) begin
         rs.status = ST_NOKEY;
      end else if (rq.opcode == OP_PACKET) begin
         if (rq.counter < m_next_ctr) begin
            rs.status = ST_REPLAY;
         end else begin
            m_next_ctr = rq.counter + 32'd1;
            if (m_held + 2 <= DEPTH) begin
               ks = keystream({m_nonce, rq.counter, 32'h0});
               m_store[m_wr] = rq.chigh ^ ks[127:64];
               m_wr = (m_wr + 1) % DEPTH;
               m_store[m_wr] = rq.clow ^ ks[63:0];
               m_wr = (m_wr + 1) % DEPTH;
               m_held += 2;
               rs.status = ST_QUEUED;
            end else begin
               rs.status = ST_FULL;
            end
         end
      end else if (m_held == 0) begin
         rs.status = ST_EMPTY;
      end else begin
         rs.report = m_store[m_rd];
         m_rd = (m_rd + 1) % DEPTH;
         m_held -= 1;
         rs.status = ST_GIVEN;
      end
      rs.occupancy = m_held[5:0];
      return rs;
   endfunction

   // note a request transfer at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
   end

   // drive requests at the falling edge; predict on each transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            expected_rsps.push_back(predict_report({req_opcode, req_packet_counter,
                                                    req_cipher_high, req_cipher_low}));
         end
         if (!req_valid || req_fire) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 7) - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               {req_opcode, req_packet_counter, req_cipher_high, req_cipher_low}
                  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         // random back-pressure on the response side
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // check each response transfer against the oldest prediction
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response status=%0d report=%h occ=%0d",
                     $time, rsp_status, rsp_report, rsp_occupancy);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
            if (rsp_report !== want.report) begin
               errors++;
               $display("%0t: report expected %h actual %h", $time, want.report, rsp_report);
            end
            if (rsp_occupancy !== want.occupancy) begin
               errors++;
               $display("%0t: occupancy expected %0d actual %0d", $time,
                        want.occupancy, rsp_occupancy);
            end
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_KEY_HIGH:  m_key_high = val;
         CSR_KEY_LOW:   m_key_low = val;
         CSR_NONCE:     m_nonce = val;
         CSR_KEY_READY: m_key_ready = val[0];
         default: begin
         end
      endcase
   endtask

   task automatic queue_req(input logic [1:0] op, input logic [31:0] ctr,
                            input logic [63:0] hi, input logic [63:0] lo);
      pending_reqs.push_back({op, ctr, hi, lo});
   endtask

   // wait for all transfers and responses, then let the block settle
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   // one random phase: mostly non-decreasing-counter packets and pops
   task automatic random_phase(input int count, inout logic [31:0] ctr);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            ctr = ctr + $urandom_range(0, 3);
            queue_req(OP_PACKET, ctr, rnd64(), rnd64());
         end else if (pick < 85) begin
            queue_req(OP_POP, $urandom(), rnd64(), rnd64());
         end else if (pick < 92) begin
            queue_req(OP_PACKET, $urandom(), rnd64(), rnd64());
         end else if (pick < 97) begin
            queue_req(OP_RESET, $urandom(), rnd64(), rnd64());
            ctr = $urandom_range(0, 50);
         end else begin
            queue_req(OP_SPARE, $urandom(), rnd64(), rnd64());
         end
      end
   endtask

   initial begin
      logic [31:0] ctr;
      m_key_high = '0; m_key_low = '0; m_nonce = '0; m_key_ready = 1'b0;
      m_rd = 0; m_wr = 0; m_held = 0; m_next_ctr = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: key not ready and unused op, then zero key, wrap, replay, fill
      queue_req(OP_PACKET, 32'd5, '1, '1);
      queue_req(OP_POP, '0, '0, '0);
      queue_req(OP_RESET, '1, '1, '1);
      queue_req(OP_SPARE, '1, '1, '1);
      drain();
      write_reg(CSR_KEY_HIGH, '0);
      write_reg(CSR_KEY_LOW, '0);
      write_reg(CSR_NONCE, '0);
      write_reg(CSR_KEY_READY, 64'd1);
      queue_req(OP_POP, '0, '0, '0);
      queue_req(OP_PACKET, 32'd0, '0, '0);
      queue_req(OP_PACKET, 32'hFFFF_FFFF, '1, '1);
      queue_req(OP_PACKET, 32'd0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      queue_req(OP_PACKET, 32'd1, '1, '0);
      queue_req(OP_PACKET, 32'd0, '1, '0);
      queue_req(OP_RESET, '0, '0, '0);
      for (int i = 0; i < 16; i++) queue_req(OP_PACKET, 32'd10 + i, rnd64(), rnd64());
      queue_req(OP_POP, '1, '1, '1);
      queue_req(OP_PACKET, 32'd40, '1, '1);
      drain();

      // key and IV at all ones
      write_reg(CSR_KEY_HIGH, '1);
      write_reg(CSR_KEY_LOW, '1);
      write_reg(CSR_NONCE, '1);
      ctr = 32'hFFFF_FFF0;
      random_phase(150, ctr);
      drain();

      // random settings; key dropped for a while
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_KEY_HIGH, rnd64());
         write_reg(CSR_KEY_LOW, rnd64());
         write_reg(CSR_NONCE, rnd64());
         write_reg(CSR_KEY_READY, (p == 2) ? 64'd0 : 64'd1);
         ctr = $urandom_range(0, 100);
         queue_req(OP_RESET, '0, '0, '0);
         random_phase(150, ctr);
         drain();
      end

      // last part with no idling on either side
      write_reg(CSR_KEY_READY, 64'd1);
      calm = 1'b1;
      ctr = 0;
      queue_req(OP_RESET, '0, '0, '0);
      random_phase(100, ctr);
      drain();

      if (errors == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/crrq_pkg.sv
hw/rtl/crrq_ram.sv
hw/rtl/ctr_decrypt_replay_report_queue.sv
bench/ctr_decrypt_replay_report_queue_tb.sv
